// File: sv/assert_macros.svh
// assertion macros shared by the page table walker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PTW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("page table walker assertion failed");
// condition must never be true outside reset
`define PTW_ASSERT_NEVER(label, clk, rst_n, cond) \
  `PTW_ASSERT(label, clk, rst_n, !(cond))
`else
`define PTW_ASSERT(label, clk, rst_n, prop)
`define PTW_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: sv/ptw_pkg.sv
// shared constants, types and helpers of the page table walker
package ptw_pkg;

  // store geometry
  localparam int TablePages      = 16;
  localparam int EntriesPerTable = 512;
  localparam int IdxW            = $clog2(EntriesPerTable);
  localparam int PageIdxW        = $clog2(TablePages);
  localparam int AddrW           = PageIdxW + IdxW;
  localparam int MemDepth        = TablePages * EntriesPerTable;

  // field widths
  localparam int EntryW = 64;
  localparam int FrameW = 40;
  localparam int PageW  = 4;
  localparam int VpnW   = 36;

  // entry bit positions
  localparam int PresentBit = 0;
  localparam int LargeBit   = 7;
  localparam int FrameLsb   = 12;

  // commands
  localparam logic CmdWrite   = 1'b0;
  localparam logic CmdResolve = 1'b1;

  // page size codes
  localparam logic [1:0] SizeNone = 2'd0;
  localparam logic [1:0] Size4K   = 2'd1;
  localparam logic [1:0] Size2M   = 2'd2;
  localparam logic [1:0] Size1G   = 2'd3;

  // memory access request from walker to store
  typedef struct packed {
    logic              we;
    logic              re;
    logic [AddrW-1:0]  addr;
    logic [EntryW-1:0] wdata;
  } mem_req_t;

  // one result transaction
  typedef struct packed {
    logic              found;
    logic              fault;
    logic [FrameW-1:0] frame;
    logic [1:0]        size;
    logic [PageW-1:0]  ptr_page;
    logic [PageW-1:0]  pd_page;
    logic [PageW-1:0]  pt_page;
  } walk_res_t;

  // page number lies inside the store
  function automatic logic in_store(logic [FrameW-1:0] page);
    return page < FrameW'(TablePages);
  endfunction

  // flat store address of an entry
  function automatic logic [AddrW-1:0] mk_addr(logic [FrameW-1:0] page,
                                               logic [IdxW-1:0] idx);
    return {page[PageIdxW-1:0], idx};
  endfunction

endpackage

// File: sv/four_level_page_table_walker_top.sv
// four-level page table walker: root register, walker, store, output register
// a resolve reads one store entry per level from the root table down and ends
//   early on a non-present entry, a large page or a table page outside the store
// a new resolve waits until the output register takes the last result; one entry
//   write per cycle while that register takes each result and the store is ready
// reset: sweep zeroes 16x512 entries, none accepted; root_table_page resets to 0
`include "assert_macros.svh"

module four_level_page_table_walker_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [ptw_pkg::PageW-1:0]    cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [ptw_pkg::PageW-1:0]    table_page_i,
  input  logic [ptw_pkg::IdxW-1:0]     entry_index_i,
  input  logic [ptw_pkg::EntryW-1:0]   entry_value_i,
  input  logic [ptw_pkg::VpnW-1:0]     virtual_page_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic                         fault_o,
  output logic [ptw_pkg::FrameW-1:0]   frame_number_o,
  output logic [1:0]                   size_code_o,
  output logic [ptw_pkg::PageW-1:0]    pointer_table_page_o,
  output logic [ptw_pkg::PageW-1:0]    directory_page_o,
  output logic [ptw_pkg::PageW-1:0]    leaf_table_page_o
);

  logic [ptw_pkg::PageW-1:0]  root_q;
  ptw_pkg::mem_req_t          req;
  logic [ptw_pkg::EntryW-1:0] rdata;
  logic                       store_ready;
  ptw_pkg::walk_res_t         res;
  logic                       res_valid;
  logic                       load;
  logic                       out_valid_q, out_valid_d;
  ptw_pkg::walk_res_t         out_q;

  // root table register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  ptw_walk u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .table_page_i   (table_page_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .virtual_page_i (virtual_page_i),
    .root_page_i    (root_q),
    .store_ready_i  (store_ready),
    .rdata_i        (rdata),
    .req_o          (req),
    .res_o          (res),
    .res_valid_o    (res_valid),
    .res_take_i     (load)
  );

  ptw_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata),
    .ready_o (store_ready)
  );

  // output register
  assign load        = res_valid & (~out_valid_q | out_ready_i);
  assign out_valid_d = load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign found_o              = out_q.found;
  assign fault_o              = out_q.fault;
  assign frame_number_o       = out_q.frame;
  assign size_code_o          = out_q.size;
  assign pointer_table_page_o = out_q.ptr_page;
  assign directory_page_o     = out_q.pd_page;
  assign leaf_table_page_o    = out_q.pt_page;

  // checks
  `PTW_ASSERT_NEVER(a_no_accept_clearing, clk_i, rst_ni, in_valid_i && in_ready_o && !store_ready)
  `PTW_ASSERT(a_write_done_next, clk_i, rst_ni, (in_valid_i && in_ready_o && command_i == ptw_pkg::CmdWrite) |=> res_valid)
  `PTW_ASSERT(a_found_sized, clk_i, rst_ni, (out_valid_o && found_o) |-> (size_code_o != ptw_pkg::SizeNone && !fault_o))
  `PTW_ASSERT(a_fault_no_map, clk_i, rst_ni, (out_valid_o && fault_o) |-> (!found_o && frame_number_o == '0))

endmodule

// File: sv/ptw_store.sv
// table entry memory with post-reset clearing sweep
module ptw_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptw_pkg::mem_req_t            req_i,
  output logic [ptw_pkg::EntryW-1:0]   rdata_o,
  output logic                         ready_o
);

  logic [ptw_pkg::EntryW-1:0] mem_q [ptw_pkg::MemDepth];
  logic [ptw_pkg::EntryW-1:0] rdata_q;
  logic                       clr_busy_q, clr_busy_d;
  logic [ptw_pkg::AddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic                       we;
  logic [ptw_pkg::AddrW-1:0]  waddr;
  logic [ptw_pkg::EntryW-1:0] wdata;

  // clearing sweep, one entry per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + ptw_pkg::AddrW'(1);
      if (clr_cnt_q == ptw_pkg::AddrW'(ptw_pkg::MemDepth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // write port mux: sweep wins while clearing
  assign we    = clr_busy_q | req_i.we;
  assign waddr = clr_busy_q ? clr_cnt_q : req_i.addr;
  assign wdata = clr_busy_q ? '0 : req_i.wdata;

  // memory array
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = ~clr_busy_q;

endmodule

// File: sv/ptw_walk.sv
// walk sequencer: entry writes and four-level translation
module ptw_walk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [ptw_pkg::PageW-1:0]    table_page_i,
  input  logic [ptw_pkg::IdxW-1:0]     entry_index_i,
  input  logic [ptw_pkg::EntryW-1:0]   entry_value_i,
  input  logic [ptw_pkg::VpnW-1:0]     virtual_page_i,
  input  logic [ptw_pkg::PageW-1:0]    root_page_i,
  input  logic                         store_ready_i,
  input  logic [ptw_pkg::EntryW-1:0]   rdata_i,
  output ptw_pkg::mem_req_t            req_o,
  output ptw_pkg::walk_res_t           res_o,
  output logic                         res_valid_o,
  input  logic                         res_take_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // table level whose entry sits in the read data
  localparam logic [1:0] LvlPt   = 2'd0;
  localparam logic [1:0] LvlPd   = 2'd1;
  localparam logic [1:0] LvlPdpt = 2'd2;
  localparam logic [1:0] LvlRoot = 2'd3;

  localparam int RestW = 3 * ptw_pkg::IdxW;

  logic [1:0]               state_q, state_d;
  logic [1:0]               lvl_q, lvl_d;
  logic [RestW-1:0]         vp_q, vp_d;
  ptw_pkg::walk_res_t       res_q, res_d;

  logic                        accept;
  logic                        present;
  logic                        big_pg;
  logic [ptw_pkg::FrameW-1:0]  frame;
  logic [ptw_pkg::IdxW-1:0]    next_idx;

  assign in_ready_o = store_ready_i &
                      ((state_q == StIdle) | ((state_q == StDone) & res_take_i));
  assign accept     = in_valid_i & in_ready_o;

  // decode the entry just read
  assign present = rdata_i[ptw_pkg::PresentBit];
  assign big_pg  = rdata_i[ptw_pkg::LargeBit];
  assign frame   = rdata_i[ptw_pkg::FrameLsb +: ptw_pkg::FrameW];

  // index into the next lower table
  always_comb begin
    unique case (lvl_q)
      LvlRoot: next_idx = vp_q[2*ptw_pkg::IdxW +: ptw_pkg::IdxW];
      LvlPdpt: next_idx = vp_q[ptw_pkg::IdxW +: ptw_pkg::IdxW];
      default: next_idx = vp_q[0 +: ptw_pkg::IdxW];
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    vp_d    = vp_q;
    res_d   = res_q;
    req_o   = '0;

    unique case (state_q)
      StIdle: begin
      end
      StDone: begin
        if (res_take_i) begin
          state_d = StIdle;
        end
      end
      StWalk: begin
        priority if (!present) begin
          state_d = StDone;
        end else if (lvl_q == LvlPt) begin
          res_d.found = 1'b1;
          res_d.frame = frame;
          res_d.size  = ptw_pkg::Size4K;
          state_d     = StDone;
        end else if (big_pg && (lvl_q != LvlRoot)) begin
          res_d.found = 1'b1;
          res_d.frame = frame;
          res_d.size  = (lvl_q == LvlPdpt) ? ptw_pkg::Size1G : ptw_pkg::Size2M;
          state_d     = StDone;
        end else if (!ptw_pkg::in_store(frame)) begin
          res_d.fault = 1'b1;
          state_d     = StDone;
        end else begin
          // descend one level
          unique case (lvl_q)
            LvlRoot: res_d.ptr_page = frame[ptw_pkg::PageW-1:0];
            LvlPdpt: res_d.pd_page  = frame[ptw_pkg::PageW-1:0];
            default: res_d.pt_page  = frame[ptw_pkg::PageW-1:0];
          endcase
          req_o.re   = 1'b1;
          req_o.addr = ptw_pkg::mk_addr(frame, next_idx);
          lvl_d      = lvl_q - 2'd1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // new transaction
    if (accept) begin
      res_d = '0;
      if (command_i == ptw_pkg::CmdWrite) begin
        if (ptw_pkg::in_store(ptw_pkg::FrameW'(table_page_i))) begin
          req_o.we    = 1'b1;
          req_o.addr  = ptw_pkg::mk_addr(ptw_pkg::FrameW'(table_page_i), entry_index_i);
          req_o.wdata = entry_value_i;
        end else begin
          res_d.fault = 1'b1;
        end
        state_d = StDone;
      end else if (!ptw_pkg::in_store(ptw_pkg::FrameW'(root_page_i))) begin
        res_d.fault = 1'b1;
        state_d     = StDone;
      end else begin
        req_o.re   = 1'b1;
        req_o.addr = ptw_pkg::mk_addr(ptw_pkg::FrameW'(root_page_i),
                                      virtual_page_i[RestW +: ptw_pkg::IdxW]);
        vp_d       = virtual_page_i[RestW-1:0];
        lvl_d      = LvlRoot;
        state_d    = StWalk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lvl_q   <= LvlRoot;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vp_q  <= vp_d;
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = (state_q == StDone);

endmodule
